/* rtl/i2cblm_pkg.sv */
// Shared types and constants of the I2C bit-level master.
package i2cblm_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	localparam int unsigned HALF_W = 16;
	localparam int unsigned STEP_W = 5;
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned OUT_TDATA_W = 16;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd50;

	localparam logic [STEP_W-1:0] STEPS_SHORT = 5'd4;
	localparam logic [STEP_W-1:0] STEPS_WRITE = 5'd18;
	localparam logic [STEP_W-1:0] STEPS_READ  = 5'd19;
	localparam logic [STEP_W-1:0] READ_ANSWER_STEP = 5'd16;
	localparam logic [STEP_W-1:0] READ_CLOCK_STEP  = 5'd17;

endpackage

/* rtl/i2c_bit_level_master_top.sv */
// I2C bit-level master: command sequencer with one base tick per input beat.
// Each accepted input beat registers its result beat in the output register.
// Throughput: one beat per cycle unless a result beat stalls; the state update
// and line drives form one combinational pass, sequencer to output registers.
// Reset: asynchronous, active low; both lines released, sequencer idle,
// half period 50 ticks, no result beat pending.
module i2c_bit_level_master_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [i2cblm_pkg::HALF_W-1:0]          cfg_wdata,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// cmd_valid, func[1:0], tx_byte[7:0], send_ack, sda_in, zero padding
	input  logic [i2cblm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// scl_level, sda_level, ready_res, rx_byte[7:0], rx_done, zero padding
	output logic [i2cblm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	logic [i2cblm_pkg::HALF_W-1:0] half_q;
	logic                          busy_q;
	logic [i2cblm_pkg::STEP_W-1:0] phase_q;
	logic [i2cblm_pkg::HALF_W-1:0] tick_q;
	i2cblm_pkg::cmd_t              cmd_q;
	logic [7:0]                    shift_q;
	logic                          ack_q;
	logic                          scl_q;
	logic                          sda_q;
	logic [7:0]                    rx_q;
	logic                          out_valid_q;
	logic [i2cblm_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic                          busy_d;
	logic [i2cblm_pkg::STEP_W-1:0] phase_d;
	logic [i2cblm_pkg::HALF_W-1:0] tick_d;
	i2cblm_pkg::cmd_t              cmd_d;
	logic [7:0]                    shift_d;
	logic                          ack_d;
	logic                          scl_d;
	logic                          sda_d;
	logic [7:0]                    rx_d;
	logic                          done_d;

	logic                          in_cmd_valid;
	i2cblm_pkg::cmd_t              in_func;
	logic [7:0]                    in_tx_byte;
	logic                          in_send_ack;
	logic                          in_sda;
	logic                          accept;

	assign in_cmd_valid = s_axis_tdata[0];
	assign in_func      = i2cblm_pkg::cmd_t'(s_axis_tdata[2:1]);
	assign in_tx_byte   = s_axis_tdata[10:3];
	assign in_send_ack  = s_axis_tdata[11];
	assign in_sda       = s_axis_tdata[12];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		logic [i2cblm_pkg::HALF_W-1:0] hp;
		logic [i2cblm_pkg::HALF_W:0]   tick_inc;
		logic [i2cblm_pkg::STEP_W-1:0] last_step;
		logic                          step_en;
		logic [i2cblm_pkg::STEP_W-1:0] step;
		logic [3:0]                    k;

		busy_d  = busy_q;
		phase_d = phase_q;
		tick_d  = tick_q;
		cmd_d   = cmd_q;
		shift_d = shift_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		rx_d    = rx_q;
		done_d  = 1'b0;
		step_en = 1'b0;
		step    = phase_q;
		k       = phase_q[4:1];
		hp       = (half_q == '0) ? i2cblm_pkg::HALF_W'(1) : half_q;
		tick_inc = {1'b0, tick_q} + 17'd1;

		unique case (cmd_q)
			i2cblm_pkg::CMD_WRITE: last_step = i2cblm_pkg::STEPS_WRITE;
			i2cblm_pkg::CMD_READ:  last_step = i2cblm_pkg::STEPS_READ;
			default:               last_step = i2cblm_pkg::STEPS_SHORT;
		endcase

		if (!busy_q) begin
			if (in_cmd_valid) begin
				cmd_d   = in_func;
				ack_d   = in_send_ack;
				shift_d = (in_func == i2cblm_pkg::CMD_WRITE) ? in_tx_byte : 8'd0;
				phase_d = '0;
				tick_d  = '0;
				busy_d  = 1'b1;
				step_en = 1'b1;
				step    = '0;
			end
		end else begin
			tick_d = tick_inc[i2cblm_pkg::HALF_W-1:0];
			if (tick_inc >= {1'b0, hp}) begin
				tick_d  = '0;
				phase_d = phase_q + 5'd1;
				if (phase_d >= last_step) begin
					if (cmd_q == i2cblm_pkg::CMD_WRITE) begin
						scl_d = 1'b0;
					end
					if (cmd_q == i2cblm_pkg::CMD_READ) begin
						sda_d  = 1'b1;
						rx_d   = shift_q;
						done_d = 1'b1;
					end
					phase_d = '0;
					busy_d  = 1'b0;
				end else begin
					step_en = 1'b1;
					step    = phase_d;
				end
			end
		end

		k = step[4:1];
		if (step_en) begin
			unique case (cmd_d)
				i2cblm_pkg::CMD_START: begin
					priority case (step)
						5'd0:    sda_d = 1'b1;
						5'd1:    scl_d = 1'b1;
						5'd2:    sda_d = 1'b0;
						default: scl_d = 1'b0;
					endcase
				end
				i2cblm_pkg::CMD_STOP: begin
					priority case (step)
						5'd0:    scl_d = 1'b0;
						5'd1:    sda_d = 1'b0;
						5'd2:    scl_d = 1'b1;
						default: sda_d = 1'b1;
					endcase
				end
				i2cblm_pkg::CMD_WRITE: begin
					if (!step[0]) begin
						if (k != 4'd0) begin
							scl_d = 1'b0;
						end
						sda_d = (k < 4'd8) ? shift_d[3'd7 - k[2:0]] : 1'b1;
					end else begin
						scl_d = 1'b1;
					end
				end
				default: begin
					if (step < i2cblm_pkg::READ_ANSWER_STEP) begin
						if (!step[0]) begin
							if (step == '0) begin
								sda_d = 1'b1;
							end
							scl_d = 1'b1;
						end else begin
							shift_d = {shift_d[6:0], in_sda};
							scl_d   = 1'b0;
						end
					end else if (step == i2cblm_pkg::READ_ANSWER_STEP) begin
						sda_d = !ack_d;
					end else if (step == i2cblm_pkg::READ_CLOCK_STEP) begin
						scl_d = 1'b1;
					end else begin
						scl_d = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= i2cblm_pkg::HALF_PERIOD_RESET;
			busy_q      <= 1'b0;
			phase_q     <= '0;
			tick_q      <= '0;
			cmd_q       <= i2cblm_pkg::CMD_START;
			shift_q     <= '0;
			ack_q       <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_we) begin
				half_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q      <= busy_d;
				phase_q     <= phase_d;
				tick_q      <= tick_d;
				cmd_q       <= cmd_d;
				shift_q     <= shift_d;
				ack_q       <= ack_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				rx_q        <= rx_d;
				out_valid_q <= 1'b1;
				out_data_q  <= {4'd0, done_d, rx_d, !busy_d, sda_d, scl_d};
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[11]) |-> out_data_q[2])
		else $error("read completion reported while the sequencer is busy");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (phase_q == '0 && tick_q == '0))
		else $error("idle sequencer holds a stale step or tick count");

	a_short_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cmd_q == i2cblm_pkg::CMD_START || cmd_q == i2cblm_pkg::CMD_STOP))
		|-> (phase_q < i2cblm_pkg::STEPS_SHORT))
		else $error("start or stop sequence ran past its last step");

	a_beat_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_data_q[2] == !busy_q && out_data_q[0] == scl_q
			&& out_data_q[1] == sda_q))
		else $error("result beat disagrees with the sequencer state");

endmodule
